// ===== rtl/mfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI file stream parser package
// Result kinds, error codes, parse phases and shared types.
// ----------------------------------------------------------------------------
package mfsp_pkg;

    localparam int VLQ_MAX_BYTES_DEF = 4;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_TRACK  = 3'd1;
    localparam logic [2:0] KIND_CHAN   = 3'd2;
    localparam logic [2:0] KIND_META   = 3'd3;
    localparam logic [2:0] KIND_MBYTE  = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;
    localparam logic [2:0] KIND_DONE   = 3'd6;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_HMAGIC   = 4'd1;
    localparam logic [3:0] ERR_HSIZE    = 4'd2;
    localparam logic [3:0] ERR_TMAGIC   = 4'd3;
    localparam logic [3:0] ERR_OVERRUN  = 4'd4;
    localparam logic [3:0] ERR_STATUS   = 4'd5;
    localparam logic [3:0] ERR_NORUN    = 4'd6;
    localparam logic [3:0] ERR_TRUNC    = 4'd7;
    localparam logic [3:0] ERR_LONGNUM  = 4'd8;

    localparam logic [3:0] PH_HMAGIC  = 4'd0;
    localparam logic [3:0] PH_HSIZE   = 4'd1;
    localparam logic [3:0] PH_HFMT    = 4'd2;
    localparam logic [3:0] PH_HTRK    = 4'd3;
    localparam logic [3:0] PH_HDIV    = 4'd4;
    localparam logic [3:0] PH_TMAGIC  = 4'd5;
    localparam logic [3:0] PH_TSIZE   = 4'd6;
    localparam logic [3:0] PH_DELTA   = 4'd7;
    localparam logic [3:0] PH_STATUS  = 4'd8;
    localparam logic [3:0] PH_DATA1   = 4'd9;
    localparam logic [3:0] PH_DATA2   = 4'd10;
    localparam logic [3:0] PH_MTYPE   = 4'd11;
    localparam logic [3:0] PH_MLEN    = 4'd12;
    localparam logic [3:0] PH_PAYLOAD = 4'd13;
    localparam logic [3:0] PH_DONE    = 4'd14;
    localparam logic [3:0] PH_ERROR   = 4'd15;

    localparam int RES_W = 3 + 4 + 16 + 28 + 32 + 8 + 8 + 8 + 8 + 28 + 8;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [3:0]  error_code;
        logic [15:0] word_value;
        logic [27:0] delta_time;
        logic [31:0] absolute_time;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [7:0]  meta_kind;
        logic [27:0] meta_length;
        logic [7:0]  payload_byte;
    } result_t;

    // Results of one input request: up to two
    typedef struct packed {
        logic    two;
        logic    any;
        result_t first;
        result_t second;
    } step_out_t;

    function automatic logic [7:0] head_tag(input logic [1:0] i);
        case (i)
            2'd0: head_tag = 8'h4D;
            2'd1: head_tag = 8'h54;
            2'd2: head_tag = 8'h68;
            default: head_tag = 8'h64;
        endcase
    endfunction

    function automatic logic [7:0] track_tag(input logic [1:0] i);
        case (i)
            2'd0: track_tag = 8'h4D;
            2'd1: track_tag = 8'h54;
            2'd2: track_tag = 8'h72;
            default: track_tag = 8'h6B;
        endcase
    endfunction

endpackage

// ===== rtl/mfsp_parse.sv =====
// ----------------------------------------------------------------------------
// MIDI file parse step
// Parse state and the one-byte update; emits up to two results per request.
// ----------------------------------------------------------------------------
module mfsp_parse
    import mfsp_pkg::*;
#(
    parameter int VLQ_MAX_BYTES = VLQ_MAX_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  logic [7:0] in_byte,
    input  logic      in_end,
    output step_out_t res
);

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] trk_exp_reg, trk_exp_next;
    logic [15:0] trk_done_reg, trk_done_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [7:0]  run_reg, run_next;
    logic [31:0] time_reg, time_next;
    logic [27:0] delta_reg, delta_next;
    logic [31:0] ev_reg, ev_next;
    logic [27:0] pay_reg, pay_next;

    logic [2:0]  cnt_inc;
    logic [27:0] vlq_acc;
    logic [31:0] acc_sh8;
    logic [15:0] word16;
    logic [15:0] trk_inc;
    logic [27:0] pidx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HMAGIC;
            cnt_reg      <= '0;
            acc_reg      <= '0;
            trk_exp_reg  <= '0;
            trk_done_reg <= '0;
            chunk_reg    <= '0;
            run_reg      <= '0;
            time_reg     <= '0;
            delta_reg    <= '0;
            ev_reg       <= '0;
            pay_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            acc_reg      <= acc_next;
            trk_exp_reg  <= trk_exp_next;
            trk_done_reg <= trk_done_next;
            chunk_reg    <= chunk_next;
            run_reg      <= run_next;
            time_reg     <= time_next;
            delta_reg    <= delta_next;
            ev_reg       <= ev_next;
            pay_reg      <= pay_next;
        end
    end

    assign cnt_inc = cnt_reg + 3'd1;
    assign vlq_acc = {acc_reg[20:0], in_byte[6:0]};
    assign acc_sh8 = {acc_reg[23:0], in_byte};
    assign word16  = {acc_reg[7:0], in_byte};
    assign trk_inc = trk_done_reg + 16'd1;
    assign pidx    = acc_reg[27:0] - pay_reg;

    always_comb
    begin
        result_t r0;
        result_t r1;
        logic    n0;
        logic    n1;
        logic    end_ev;
        logic [31:0] ev_w;
        r0 = '0;
        r1 = '0;
        n0 = 1'b0;
        n1 = 1'b0;
        end_ev = 1'b0;
        ev_w = ev_reg;

        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        trk_exp_next  = trk_exp_reg;
        trk_done_next = trk_done_reg;
        chunk_next    = chunk_reg;
        run_next      = run_reg;
        time_next     = time_reg;
        delta_next    = delta_reg;
        ev_next       = ev_reg;
        pay_next      = pay_reg;

        if (phase_reg == PH_DONE || phase_reg == PH_ERROR)
        begin
            // silent
        end
        else if (in_end)
        begin
            n0 = 1'b1;
            r0.result_kind = KIND_ERROR;
            r0.error_code = ERR_TRUNC;
            phase_next = PH_ERROR;
        end
        else if (phase_reg >= PH_DELTA && phase_reg <= PH_PAYLOAD && chunk_reg == 32'd0)
        begin
            n0 = 1'b1;
            r0.result_kind = KIND_ERROR;
            r0.error_code = ERR_OVERRUN;
            phase_next = PH_ERROR;
        end
        else
        begin
            if (phase_reg >= PH_DELTA && phase_reg <= PH_PAYLOAD)
                chunk_next = chunk_reg - 32'd1;
            case (phase_reg)
                PH_HMAGIC, PH_TMAGIC:
                begin
                    if (in_byte != ((phase_reg == PH_HMAGIC) ? head_tag(cnt_reg[1:0])
                                                              : track_tag(cnt_reg[1:0])))
                    begin
                        n0 = 1'b1;
                        r0.result_kind = KIND_ERROR;
                        r0.error_code = (phase_reg == PH_HMAGIC) ? ERR_HMAGIC : ERR_TMAGIC;
                        phase_next = PH_ERROR;
                    end
                    else if (cnt_inc >= 3'd4)
                    begin
                        phase_next = (phase_reg == PH_HMAGIC) ? PH_HSIZE : PH_TSIZE;
                        cnt_next = '0;
                        acc_next = '0;
                    end
                    else
                        cnt_next = cnt_inc;
                end
                PH_HSIZE, PH_TSIZE:
                begin
                    acc_next = acc_sh8;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 3'd4)
                    begin
                        if (phase_reg == PH_HSIZE)
                        begin
                            if (acc_sh8 != 32'd6)
                            begin
                                n0 = 1'b1;
                                r0.result_kind = KIND_ERROR;
                                r0.error_code = ERR_HSIZE;
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                phase_next = PH_HFMT;
                                cnt_next = '0;
                                acc_next = '0;
                            end
                        end
                        else
                        begin
                            chunk_next = acc_sh8;
                            run_next = '0;
                            time_next = '0;
                            n0 = 1'b1;
                            r0.result_kind = KIND_TRACK;
                            r0.word_value = trk_done_reg;
                            if (acc_sh8 != 32'd0)
                            begin
                                phase_next = PH_DELTA;
                                cnt_next = '0;
                                acc_next = '0;
                            end
                            else
                            begin
                                trk_done_next = trk_inc;
                                if (trk_inc == trk_exp_reg)
                                begin
                                    n1 = 1'b1;
                                    r1.result_kind = KIND_DONE;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_TMAGIC;
                                    cnt_next = '0;
                                    acc_next = '0;
                                end
                            end
                        end
                    end
                end
                PH_HFMT, PH_HTRK, PH_HDIV:
                begin
                    acc_next = {16'd0, word16};
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 3'd2)
                    begin
                        n0 = 1'b1;
                        r0.result_kind = KIND_HEADER;
                        r0.word_value = word16;
                        cnt_next = '0;
                        acc_next = '0;
                        if (phase_reg == PH_HFMT)
                            phase_next = PH_HTRK;
                        else if (phase_reg == PH_HTRK)
                        begin
                            trk_exp_next = word16;
                            phase_next = PH_HDIV;
                        end
                        else if (trk_exp_reg == 16'd0)
                        begin
                            n1 = 1'b1;
                            r1.result_kind = KIND_DONE;
                            phase_next = PH_DONE;
                            cnt_next = cnt_inc;
                            acc_next = {16'd0, word16};
                        end
                        else
                            phase_next = PH_TMAGIC;
                    end
                end
                PH_DELTA, PH_MLEN:
                begin
                    acc_next = {4'd0, vlq_acc};
                    cnt_next = cnt_inc;
                    if (in_byte[7])
                    begin
                        if (32'(cnt_inc) >= 32'(VLQ_MAX_BYTES))
                        begin
                            n0 = 1'b1;
                            r0.result_kind = KIND_ERROR;
                            r0.error_code = ERR_LONGNUM;
                            phase_next = PH_ERROR;
                        end
                    end
                    else if (phase_reg == PH_DELTA)
                    begin
                        delta_next = vlq_acc;
                        time_next = time_reg + {4'd0, vlq_acc};
                        phase_next = PH_STATUS;
                    end
                    else
                    begin
                        pay_next = vlq_acc;
                        n0 = 1'b1;
                        r0.result_kind = KIND_META;
                        r0.meta_length = vlq_acc;
                        if (vlq_acc == 28'd0)
                            end_ev = 1'b1;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
                PH_STATUS:
                begin
                    ev_w = '0;
                    if (!in_byte[7])
                    begin
                        if (!run_reg[7] || run_reg >= 8'hF0)
                        begin
                            n0 = 1'b1;
                            r0.result_kind = KIND_ERROR;
                            r0.error_code = ERR_NORUN;
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            ev_w = {16'd0, in_byte, run_reg};
                            if (run_reg >= 8'hC0 && run_reg <= 8'hDF)
                            begin
                                n0 = 1'b1;
                                r0.result_kind = KIND_CHAN;
                                end_ev = 1'b1;
                            end
                            else
                                phase_next = PH_DATA2;
                        end
                    end
                    else if (in_byte < 8'hF0)
                    begin
                        run_next = in_byte;
                        ev_w = {24'd0, in_byte};
                        phase_next = PH_DATA1;
                    end
                    else if (in_byte == 8'hFF)
                    begin
                        run_next = '0;
                        ev_w = {24'd0, in_byte};
                        phase_next = PH_MTYPE;
                    end
                    else if (in_byte == 8'hF0 || in_byte == 8'hF7)
                    begin
                        run_next = '0;
                        ev_w = {in_byte, 16'd0, in_byte};
                        phase_next = PH_MLEN;
                        cnt_next = '0;
                        acc_next = '0;
                    end
                    else
                    begin
                        n0 = 1'b1;
                        r0.result_kind = KIND_ERROR;
                        r0.error_code = ERR_STATUS;
                        phase_next = PH_ERROR;
                    end
                    ev_next = ev_w;
                end
                PH_DATA1:
                begin
                    ev_w = ev_reg | {16'd0, in_byte, 8'd0};
                    ev_next = ev_w;
                    if (ev_reg[7:0] >= 8'hC0 && ev_reg[7:0] <= 8'hDF)
                    begin
                        n0 = 1'b1;
                        r0.result_kind = KIND_CHAN;
                        end_ev = 1'b1;
                    end
                    else
                        phase_next = PH_DATA2;
                end
                PH_DATA2:
                begin
                    ev_w = ev_reg | {8'd0, in_byte, 16'd0};
                    ev_next = ev_w;
                    n0 = 1'b1;
                    r0.result_kind = KIND_CHAN;
                    end_ev = 1'b1;
                end
                PH_MTYPE:
                begin
                    ev_w = ev_reg | {in_byte, 24'd0};
                    ev_next = ev_w;
                    phase_next = PH_MLEN;
                    cnt_next = '0;
                    acc_next = '0;
                end
                default:
                begin
                    // payload byte
                    if (pidx == 28'd0)
                        ev_w = ev_reg | {16'd0, in_byte, 8'd0};
                    else if (pidx == 28'd1)
                        ev_w = ev_reg | {8'd0, in_byte, 16'd0};
                    ev_next = ev_w;
                    n0 = 1'b1;
                    r0.result_kind = KIND_MBYTE;
                    r0.meta_length = acc_reg[27:0];
                    r0.payload_byte = in_byte;
                    pay_next = pay_reg - 28'd1;
                    if (pay_reg == 28'd1)
                        end_ev = 1'b1;
                end
            endcase

            // event fields on channel / meta results
            if (n0 && (r0.result_kind == KIND_CHAN || r0.result_kind == KIND_META
                       || r0.result_kind == KIND_MBYTE))
            begin
                r0.delta_time    = delta_next;
                r0.absolute_time = time_next;
                r0.status_byte   = ev_w[7:0];
                r0.first_data    = ev_w[15:8];
                r0.second_data   = ev_w[23:16];
                if (r0.result_kind != KIND_CHAN)
                    r0.meta_kind = ev_w[31:24];
            end

            if (end_ev)
            begin
                if (chunk_next != 32'd0)
                begin
                    phase_next = PH_DELTA;
                    cnt_next = '0;
                    acc_next = '0;
                end
                else
                begin
                    trk_done_next = trk_inc;
                    if (trk_inc == trk_exp_reg)
                    begin
                        n1 = 1'b1;
                        r1.result_kind = KIND_DONE;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_TMAGIC;
                        cnt_next = '0;
                        acc_next = '0;
                    end
                end
            end
        end

        // a single done result rides in the first slot
        res.any = n0 | n1;
        res.two = n0 & n1;
        res.first = n0 ? r0 : r1;
        res.second = r1;
    end

endmodule

// ===== rtl/mfsp_out.sv =====
// ----------------------------------------------------------------------------
// MIDI file result output stage
// Two-entry result register; drains one result per cycle to the stream port while it is ready.
// ----------------------------------------------------------------------------
module mfsp_out
    import mfsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  step_out_t res,
    output logic      can_load,
    input  logic      out_ready,
    output logic      out_valid,
    output result_t   out_res,
    output logic      out_last
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    e0_reg, e1_reg;
    logic       l0_reg, l1_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid & out_ready;
    // accept when we end up empty enough for a pair
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign out_res   = e0_reg;
    assign out_last  = l0_reg;

    always_comb
    begin
        cnt_next = cnt_reg - {1'b0, pop};
        if (load && res.any)
            cnt_next = res.two ? 2'd2 : 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && res.any)
        begin
            e0_reg <= res.first;
            l0_reg <= !res.two;
            e1_reg <= res.second;
            l1_reg <= 1'b1;
        end
        else if (pop)
        begin
            e0_reg <= e1_reg;
            l0_reg <= l1_reg;
        end
    end

endmodule

// ===== rtl/midi_file_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// MIDI file stream parser core
// Parses a Standard MIDI File one byte per request into header, track,
// event, meta and error results.
// ----------------------------------------------------------------------------
// A result is registered and on the output in the cycle after its input request.
// Throughput: one byte per cycle while results are taken; a byte yielding two
// results (file done after a final event, a track start or the last header
// word) holds input while the pair drains, and input also waits while a
// single result is stalled at the output.
// Reset: rst_n clears parse state and empties the output register.
module midi_file_stream_parser_core
    import mfsp_pkg::*;
#(
    parameter int VLQ_MAX_BYTES = VLQ_MAX_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // stream_byte
    input  logic         s_tuser,   // end_of_stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // error_code, word_value, delta_time,
                                    // absolute_time, status_byte, first_data,
                                    // second_data, meta_kind, meta_length,
                                    // payload_byte, zero fill
    output logic [2:0]   m_tuser,   // result_kind
    output logic         m_tlast    // last_in_run
);

    step_out_t res;
    result_t   o;
    logic      take;

    // request accepted; parse state advances in the same edge
    assign take = s_tvalid & s_tready;

    mfsp_parse #(.VLQ_MAX_BYTES(VLQ_MAX_BYTES)) u_parse
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (take),
        .in_byte (s_tdata),
        .in_end  (s_tuser),
        .res     (res)
    );

    mfsp_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res       (res),
        .can_load  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (o),
        .out_last  (m_tlast)
    );

    assign m_tuser = o.result_kind;
    assign m_tdata = {4'd0, o.payload_byte, o.meta_length, o.meta_kind,
                      o.second_data, o.first_data, o.status_byte,
                      o.absolute_time, o.delta_time, o.word_value, o.error_code};

endmodule

// ===== rtl/mfsp_checker.sv =====
// ----------------------------------------------------------------------------
// MIDI file parser port checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module mfsp_checker
    import mfsp_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= KIND_DONE)
        else $error("bad result kind");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tlast && m_tdata[3:0] != ERR_NONE)
        else $error("error result malformed");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_DONE |-> m_tlast)
        else $error("done not last");

    // an empty output side always takes the next request
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !m_tvalid |-> s_tready)
        else $error("input refused while output empty");

endmodule

bind midi_file_stream_parser_core mfsp_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
);

// ===== bench/testbench.sv =====
// ============================================================================
// MIDI file stream parser core testbench
// Streams one generated Standard MIDI File into the parser and checks every
// result request against a predictor built into a small scoreboard.
// ============================================================================
module testbench;
    import mfsp_pkg::*;

    localparam int VLQ_MAX = VLQ_MAX_BYTES_DEF;

    typedef struct {
        result_t res;
        bit      last;
    } midi_expect_t;

    // ------------------------------------------------------------------------
    // Scoreboard: parser predictor plus queue of results still due
    // ------------------------------------------------------------------------
    class MidiScoreboard;
        midi_expect_t due_q[$];
        result_t      step_q[$];
        int unsigned  errors;
        int unsigned  seen;

        logic [3:0]  ph;
        bit   [2:0]  cnt;
        bit   [31:0] acc;
        bit   [15:0] trk_expected;
        bit   [15:0] trk_done;
        bit   [31:0] chunk_left;
        bit   [7:0]  run_status;
        bit   [31:0] trk_time;
        bit   [27:0] ev_delta;
        bit   [31:0] ev_fields;    // status, data1, data2, meta kind
        bit   [27:0] pay_left;

        function new();
            ph = PH_HMAGIC;
            cnt = 0;
            acc = 0;
            trk_expected = 0;
            trk_done = 0;
            chunk_left = 0;
            run_status = 0;
            trk_time = 0;
            ev_delta = 0;
            ev_fields = 0;
            pay_left = 0;
            errors = 0;
            seen = 0;
        endfunction

        function result_t row(logic [2:0] k, logic [3:0] c, logic [15:0] w);
            result_t r;
            r = '0;
            r.result_kind = k;
            r.error_code = c;
            r.word_value = w;
            return r;
        endfunction

        function result_t event_row(logic [2:0] k);
            result_t r;
            r = row(k, ERR_NONE, 16'd0);
            r.delta_time = ev_delta;
            r.absolute_time = trk_time;
            r.status_byte = ev_fields[7:0];
            r.first_data = ev_fields[15:8];
            r.second_data = ev_fields[23:16];
            return r;
        endfunction

        function result_t meta_row(logic [2:0] k);
            result_t r;
            r = event_row(k);
            r.meta_kind = ev_fields[31:24];
            r.meta_length = acc[27:0];
            return r;
        endfunction

        function void fail(logic [3:0] code);
            step_q.push_back(row(KIND_ERROR, code, 16'd0));
            ph = PH_ERROR;
        endfunction

        function void start_field(logic [3:0] p);
            ph = p;
            cnt = 0;
            acc = 0;
        endfunction

        function void end_event();
            if (chunk_left != 0) begin
                start_field(PH_DELTA);
                return;
            end
            trk_done = trk_done + 16'd1;
            if (trk_done == trk_expected) begin
                step_q.push_back(row(KIND_DONE, ERR_NONE, 16'd0));
                ph = PH_DONE;
            end
            else
                start_field(PH_TMAGIC);
        endfunction

        // 1 = number complete, 0 = more bytes, -1 = too long
        function int vlq_byte(bit [7:0] b);
            acc = {4'd0, acc[20:0], b[6:0]};
            cnt++;
            if (!b[7])
                return 1;
            if (cnt >= VLQ_MAX) begin
                fail(ERR_LONGNUM);
                return -1;
            end
            return 0;
        endfunction

        function void header_word(bit [7:0] b);
            acc = {16'd0, acc[7:0], b};
            cnt++;
            if (cnt < 2)
                return;
            step_q.push_back(row(KIND_HEADER, ERR_NONE, acc[15:0]));
            if (ph == PH_HFMT)
                start_field(PH_HTRK);
            else if (ph == PH_HTRK) begin
                trk_expected = acc[15:0];
                start_field(PH_HDIV);
            end
            else if (trk_expected == 0) begin
                step_q.push_back(row(KIND_DONE, ERR_NONE, 16'd0));
                ph = PH_DONE;
            end
            else
                start_field(PH_TMAGIC);
        endfunction

        function bit one_data(bit [7:0] s);
            return s >= 8'hC0 && s <= 8'hDF;
        endfunction

        function void status_in(bit [7:0] b);
            ev_fields = 0;
            if (b < 8'h80) begin
                // data byte in status position: needs a stored channel status
                if (run_status < 8'h80 || run_status >= 8'hF0) begin
                    fail(ERR_NORUN);
                    return;
                end
                ev_fields = {16'd0, b, run_status};
                if (one_data(run_status)) begin
                    step_q.push_back(event_row(KIND_CHAN));
                    end_event();
                end
                else
                    ph = PH_DATA2;
            end
            else if (b < 8'hF0) begin
                run_status = b;
                ev_fields = {24'd0, b};
                ph = PH_DATA1;
            end
            else if (b == 8'hFF) begin
                run_status = 0;
                ev_fields = {24'd0, b};
                ph = PH_MTYPE;
            end
            else if (b == 8'hF0 || b == 8'hF7) begin
                run_status = 0;
                ev_fields = {b, 16'd0, b};
                start_field(PH_MLEN);
            end
            else
                fail(ERR_STATUS);
        endfunction

        function void track_byte(bit [7:0] b);
            int v;
            bit [27:0] idx;
            result_t r;
            case (ph)
                PH_DELTA:
                begin
                    v = vlq_byte(b);
                    if (v == 1) begin
                        ev_delta = acc[27:0];
                        trk_time = trk_time + {4'd0, ev_delta};
                        ph = PH_STATUS;
                    end
                end
                PH_STATUS:
                    status_in(b);
                PH_DATA1:
                begin
                    ev_fields[15:8] = ev_fields[15:8] | b;
                    if (one_data(ev_fields[7:0])) begin
                        step_q.push_back(event_row(KIND_CHAN));
                        end_event();
                    end
                    else
                        ph = PH_DATA2;
                end
                PH_DATA2:
                begin
                    ev_fields[23:16] = ev_fields[23:16] | b;
                    step_q.push_back(event_row(KIND_CHAN));
                    end_event();
                end
                PH_MTYPE:
                begin
                    ev_fields[31:24] = ev_fields[31:24] | b;
                    start_field(PH_MLEN);
                end
                PH_MLEN:
                begin
                    v = vlq_byte(b);
                    if (v == 1) begin
                        pay_left = acc[27:0];
                        step_q.push_back(meta_row(KIND_META));
                        if (pay_left == 0)
                            end_event();
                        else
                            ph = PH_PAYLOAD;
                    end
                end
                default:
                begin
                    // first two payload bytes are carried in the data fields
                    idx = acc[27:0] - pay_left;
                    if (idx == 0)
                        ev_fields[15:8] = ev_fields[15:8] | b;
                    else if (idx == 1)
                        ev_fields[23:16] = ev_fields[23:16] | b;
                    r = meta_row(KIND_MBYTE);
                    r.payload_byte = b;
                    step_q.push_back(r);
                    pay_left = pay_left - 28'd1;
                    if (pay_left == 0)
                        end_event();
                end
            endcase
        endfunction

        function void take_byte(bit [7:0] b);
            string tag;
            if (ph >= PH_DELTA && ph <= PH_PAYLOAD) begin
                if (chunk_left == 0) begin
                    fail(ERR_OVERRUN);
                    return;
                end
                chunk_left--;
                track_byte(b);
                return;
            end
            case (ph)
                PH_HMAGIC, PH_TMAGIC:
                begin
                    tag = (ph == PH_HMAGIC) ? "MThd" : "MTrk";
                    if (b != tag.getc(cnt[1:0]))
                        fail(ph == PH_HMAGIC ? ERR_HMAGIC : ERR_TMAGIC);
                    else begin
                        cnt++;
                        if (cnt >= 4)
                            start_field(ph == PH_HMAGIC ? PH_HSIZE : PH_TSIZE);
                    end
                end
                PH_HSIZE, PH_TSIZE:
                begin
                    acc = {acc[23:0], b};
                    cnt++;
                    if (cnt >= 4) begin
                        if (ph == PH_HSIZE) begin
                            if (acc != 32'd6)
                                fail(ERR_HSIZE);
                            else
                                start_field(PH_HFMT);
                        end
                        else begin
                            chunk_left = acc;
                            run_status = 0;
                            trk_time = 0;
                            step_q.push_back(row(KIND_TRACK, ERR_NONE, trk_done));
                            end_event();
                        end
                    end
                end
                PH_HFMT, PH_HTRK, PH_HDIV:
                    header_word(b);
                default:
                    ;
            endcase
        endfunction

        // accepted input request
        function void note_input(bit eos, bit [7:0] b);
            midi_expect_t e;
            step_q.delete();
            if (ph != PH_DONE && ph != PH_ERROR) begin
                if (eos)
                    fail(ERR_TRUNC);
                else
                    take_byte(b);
            end
            foreach (step_q[i]) begin
                e.res = step_q[i];
                e.last = (i == step_q.size() - 1);
                due_q.push_back(e);
            end
        endfunction

        function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // accepted result request
        function void check_result(result_t r, bit last);
            midi_expect_t e;
            seen++;
            if (due_q.size() == 0) begin
                $error("result_kind: expected none, got 0x%0h", r.result_kind);
                errors++;
                return;
            end
            e = due_q.pop_front();
            cmp("result_kind", e.res.result_kind, r.result_kind);
            cmp("error_code", e.res.error_code, r.error_code);
            cmp("word_value", e.res.word_value, r.word_value);
            cmp("delta_time", e.res.delta_time, r.delta_time);
            cmp("absolute_time", e.res.absolute_time, r.absolute_time);
            cmp("status_byte", e.res.status_byte, r.status_byte);
            cmp("first_data", e.res.first_data, r.first_data);
            cmp("second_data", e.res.second_data, r.second_data);
            cmp("meta_kind", e.res.meta_kind, r.meta_kind);
            cmp("meta_length", e.res.meta_length, r.meta_length);
            cmp("payload_byte", e.res.payload_byte, r.payload_byte);
            cmp("last_in_run", e.last, last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and clocking
    // ------------------------------------------------------------------------
    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;   // stream_byte
    logic         s_tuser = 1'b0;   // end_of_stream
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;          // error_code .. payload_byte, zero fill
    logic [2:0]   m_tuser;          // result_kind
    logic         m_tlast;          // last_in_run

    midi_file_stream_parser_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    MidiScoreboard sb = new();
    bit            calm = 1'b0;     // no idling in the closing part
    int unsigned   bytes_sent = 0;
    int unsigned   rx_hold = 0;
    bit [7:0]      trk[$];          // track body under construction
    bit            gen_rs;          // generator holds a channel status
    bit [7:0]      gen_st;          // that channel status

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && s_tvalid && s_tready)
            sb.note_input(s_tuser, s_tdata);
        if (rst_n && m_tvalid && m_tready) begin
            r = '0;
            r.result_kind   = m_tuser;
            r.error_code    = m_tdata[3:0];
            r.word_value    = m_tdata[19:4];
            r.delta_time    = m_tdata[47:20];
            r.absolute_time = m_tdata[79:48];
            r.status_byte   = m_tdata[87:80];
            r.first_data    = m_tdata[95:88];
            r.second_data   = m_tdata[103:96];
            r.meta_kind     = m_tdata[111:104];
            r.meta_length   = m_tdata[139:112];
            r.payload_byte  = m_tdata[147:140];
            sb.check_result(r, m_tlast);
        end
    end

    // Receiver backpressure in random bursts
    always @(negedge clk)
    begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end
        else if (!calm && rst_n && $urandom_range(0, 9) == 0) begin
            rx_hold = $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Timeout guard
    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender tasks; all called at a falling edge and return at one
    // ------------------------------------------------------------------------
    task automatic send(input bit eos, input bit [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= eos;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_word32(input bit [31:0] w);
        for (int i = 3; i >= 0; i--)
            send(1'b0, w[i*8 +: 8]);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send(1'b0, s.getc(i));
    endtask

    task automatic put_vlq(input bit [27:0] v);
        bit [6:0] grp[$];
        bit [27:0] t;
        t = v;
        do begin
            grp.push_front(t[6:0]);
            t = t >> 7;
        end while (t != 0);
        foreach (grp[i])
            trk.push_back({(i != grp.size() - 1), grp[i]});
    endtask

    task automatic put_delta(input bit big);
        case (big ? 3 : $urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: put_vlq(28'($urandom_range(0, 127)));
            6, 7: put_vlq(28'($urandom_range(128, 16383)));
            8: put_vlq(28'($urandom_range(16384, 2097151)));
            default: put_vlq(28'($urandom_range(2097152, 28'h0FFFFFF)));
        endcase
    endtask

    task automatic put_channel(input bit [7:0] st, input bit [7:0] d1,
                               input bit [7:0] d2, input bit run);
        if (!run) begin
            trk.push_back(st);
            gen_st = st;
        end
        trk.push_back(d1);
        if (!(st >= 8'hC0 && st <= 8'hDF))
            trk.push_back(d2);
        gen_rs = 1'b1;
    endtask

    task automatic put_meta(input bit [7:0] st, input bit [7:0] kind_b, input int len);
        trk.push_back(st);
        if (st == 8'hFF)
            trk.push_back(kind_b);
        put_vlq(28'(len));
        repeat (len) trk.push_back(8'($urandom_range(0, 255)));
        gen_rs = 1'b0;
    endtask

    // one random event: mostly channel traffic, sometimes with running status
    task automatic put_random_event(input bit big);
        bit [7:0] st;
        bit       run;
        put_delta(big);
        case ($urandom_range(0, 9))
            0: put_meta(8'hFF, 8'($urandom_range(0, 255)), $urandom_range(0, 6));
            1: put_meta($urandom_range(0, 1) ? 8'hF0 : 8'hF7, 8'h00,
                        $urandom_range(0, 5));
            default:
            begin
                run = gen_rs && $urandom_range(0, 2) == 0;
                if (run) begin
                    st = gen_st;
                    put_channel(st, 8'($urandom_range(0, 127)),
                                8'($urandom_range(0, 255)), 1'b1);
                end
                else begin
                    st = 8'($urandom_range(8'h80, 8'hEF));
                    put_channel(st, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 1'b0);
                end
            end
        endcase
    endtask

    task automatic send_track(input bit [31:0] size_adj);
        send_text("MTrk");
        send_word32(trk.size() + size_adj);
        foreach (trk[i])
            send(1'b0, trk[i]);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int          n_rand;
        int          ending;
        bit [7:0]    st;
        bit [31:0]   adj;
        bit [7:0]    bad;

        n_rand = 4;
        ending = $urandom_range(0, 6);
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // header: format, tracks (zero-length, directed, random, closing), division
        send_text("MThd");
        send_word32(32'd6);
        send(1'b0, 8'hFF);
        send(1'b0, 8'h00);
        send(1'b0, 8'h00);
        send(1'b0, 8'(3 + n_rand + (ending == 6)));
        send(1'b0, 8'($urandom_range(0, 255)));
        send(1'b0, 8'($urandom_range(0, 255)));

        // zero-length track: start and end back to back
        trk.delete();
        send_track(0);

        // directed track: running status, one-data channel, meta, sysex, max delta
        trk.delete();
        gen_rs = 1'b0;
        put_vlq(0);             put_channel(8'h90, 8'h3C, 8'h7F, 1'b0);
        put_vlq(127);           put_channel(8'h90, 8'h3C, 8'h00, 1'b1);
        put_vlq(28'h0FFFFFFF);  put_channel(8'hC5, 8'hFF, 8'h00, 1'b0);
        put_vlq(128);           put_channel(8'hC5, 8'h10, 8'h00, 1'b1);
        put_vlq(0);             put_meta(8'hFF, 8'h03, 3);
        put_vlq(0);             put_meta(8'hF0, 8'h00, 2);
        put_vlq(0);             put_meta(8'hF7, 8'h00, 0);
        put_vlq(0);             put_meta(8'hFF, 8'h2F, 0);
        send_track(0);

        // hold off until the parser has drained everything so far
        s_tvalid <= 1'b0;
        while (sb.due_q.size() != 0)
            @(negedge clk);

        // random tracks; the first one is heavy on short one-byte deltas
        for (int t = 0; t < n_rand; t++) begin
            trk.delete();
            gen_rs = 1'b0;
            while (trk.size() < 80)
                put_random_event(t == 0 && $urandom_range(0, 3) != 0);
            send_track(0);
        end

        // closing track ends the file or stops it with one error
        calm = 1'b1;
        trk.delete();
        gen_rs = 1'b0;
        adj = 0;
        while (trk.size() < 20)
            put_random_event(1'b0);
        case (ending)
            2:
            begin
                put_vlq(0);
                put_channel(8'h91, 8'h40, 8'h40, 1'b0);
                adj = -1;
            end
            3:
            begin
                do st = 8'($urandom_range(8'hF1, 8'hFE)); while (st == 8'hF7);
                put_vlq(0);
                trk.push_back(st);
                adj = 10;
            end
            4:
            begin
                put_vlq(0);
                put_meta(8'hFF, 8'h01, 1);
                put_vlq(0);
                trk.push_back(8'($urandom_range(0, 127)));
                adj = 10;
            end
            5:
            begin
                repeat (VLQ_MAX) trk.push_back(8'h80 | 8'($urandom_range(0, 127)));
                adj = 10;
            end
            default:
                ;
        endcase
        if (ending == 1) begin
            send_text("MTrk");
            send_word32(trk.size() + 8);
            foreach (trk[i])
                send(1'b0, trk[i]);
        end
        else
            send_track(adj);
        if (ending == 6) begin
            do bad = 8'($urandom_range(0, 255)); while (bad == 8'h72);
            send_text("MT");
            send(1'b0, bad);
        end

        // end of stream; then bytes the parser must ignore
        send(1'b1, 8'h00);
        send(1'b0, 8'h00);
        send(1'b1, 8'hFF);
        s_tvalid <= 1'b0;

        while (sb.due_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Sent %0d bytes over %0d tracks, checked %0d results, closing case %0d.",
                 bytes_sent, 3 + n_rand, sb.seen, ending);
        $display("Covered header words, running status, meta, sysex and error hold.");
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
